FILE: design/fnd_pkg.sv
// ----------------------------------------------------------------------------
// Four-neighbour despeckle package
// Pixel and window types, register indexes and constants shared by the
// despeckle filter, its line cells and the top level.
// ----------------------------------------------------------------------------
package fnd_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 2;
    localparam int DIV3_SHIFT = SUM_W + 1;
    localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;

    localparam int FW_W      = 6;
    localparam int FH_W      = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 6'd30;
    localparam logic [FH_W-1:0] FH_RESET = 11'd20;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } fnd_column_t;

    // Neighbour flags are ordered up, left, right, down from bit 0.
    typedef struct packed {
        pix_t       centre;
        pix_t       up;
        pix_t       left;
        pix_t       right;
        pix_t       down;
        logic [3:0] nb_ok;
        logic       frame_end;
        logic       run_last;
    } fnd_window_t;

endpackage

FILE: design/four_neighbour_despeckle.sv
// ----------------------------------------------------------------------------
// Four-neighbour despeckle filter
// Replaces isolated pixels of a raster stream by the rounded average of
// their up, down, left and right neighbours.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid, pixel_ready, pixel_in) in
// raster order; filtered words leave on the result channel (result_valid,
// result_ready, pixel_out, frame_end, run_last), also in raster order.
// Frame width and height are written through the cfg port while the block
// is idle; any write restarts the frame at its first pixel.
// The output trails the input by one line. A word passes through the
// first-stage registers and the output register after the pixel that
// completes its neighbourhood. The last pixel of a frame flushes the whole
// final row, with pixel_ready low meanwhile. Outside flushes and stalls,
// one pixel is taken per cycle; the rate is set by the shift of the column
// cell ring. When the receiver stalls, the output register and the stage
// before it fill, and pixel_ready falls until result_ready returns.
// Reset clears the counters and the pipeline, and loads a width of 30 and a
// height of 20. The line cells keep their contents.
// ----------------------------------------------------------------------------
module four_neighbour_despeckle #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fnd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fnd_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  fnd_pkg::pix_t                   pixel_in,
    output logic                            result_valid,
    input  logic                            result_ready,
    output fnd_pkg::pix_t                   pixel_out,
    output logic                            frame_end,
    output logic                            run_last
);
    import fnd_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [CW-1:0]   last_col;
    logic [RW-1:0]   last_row;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          flushing_reg;
    logic [CW-1:0] flush_col_reg;
    pix_t          left_reg;

    logic in_accept;
    logic at_row_end;
    logic at_frame_end;
    logic flush_step;
    logic filt_load;
    logic filt_can_load;

    fnd_column_t ring_q         [MAX_WIDTH];
    fnd_column_t ring_from_next [MAX_WIDTH];
    fnd_column_t ring_insert;
    logic        ring_shift;
    fnd_window_t window;

    always_comb
    begin
        if (fw_reg == '0)
        begin
            last_col = '0;
        end
        else if (int'(fw_reg) > MAX_WIDTH)
        begin
            last_col = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CW'(fw_reg - 1'b1);
        end

        if (fh_reg == '0)
        begin
            last_row = '0;
        end
        else if (int'(fh_reg) > MAX_HEIGHT)
        begin
            last_row = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = RW'(fh_reg - 1'b1);
        end
    end

    assign pixel_ready  = filt_can_load && !flushing_reg;
    assign in_accept    = pixel_valid && pixel_ready;
    assign flush_step   = flushing_reg && filt_can_load;
    assign at_row_end   = (col_reg == last_col);
    assign at_frame_end = at_row_end && (row_reg == last_row);
    assign filt_load    = flush_step || (in_accept && row_reg != '0);
    assign ring_shift   = in_accept || flush_step;

    always_comb
    begin
        if (flushing_reg)
        begin
            ring_insert = ring_q[0];
        end
        else
        begin
            ring_insert.upper  = ring_q[0].middle;
            ring_insert.middle = pixel_in;
        end
    end

    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_ring
        assign ring_from_next[i] = ring_q[(i + 1) % MAX_WIDTH];

        fnd_cell u_cell (
            .clk         (clk),
            .shift       (ring_shift),
            .take_insert (last_col == CW'(i)),
            .from_next   (ring_from_next[i]),
            .insert      (ring_insert),
            .data        (ring_q[i])
        );
    end

    always_comb
    begin
        window.centre = ring_q[0].middle;
        window.up     = ring_q[0].upper;
        window.left   = left_reg;
        window.right  = ring_from_next[0].middle;
        window.down   = pixel_in;
        if (flushing_reg)
        begin
            window.nb_ok[0]  = (last_row != '0);
            window.nb_ok[1]  = (flush_col_reg != '0);
            window.nb_ok[2]  = (flush_col_reg != last_col);
            window.nb_ok[3]  = 1'b0;
            window.frame_end = (flush_col_reg == last_col);
            window.run_last  = (flush_col_reg == last_col);
        end
        else
        begin
            window.nb_ok[0]  = (int'(row_reg) >= 2);
            window.nb_ok[1]  = (col_reg != '0);
            window.nb_ok[2]  = !at_row_end;
            window.nb_ok[3]  = 1'b1;
            window.frame_end = 1'b0;
            window.run_last  = !at_frame_end;
        end
    end

    fnd_filter u_filter (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (filt_load),
        .window       (window),
        .can_load     (filt_can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel_out    (pixel_out),
        .frame_end    (frame_end),
        .run_last     (run_last)
    );

    always_ff @(posedge clk)
    begin
        if (ring_shift)
        begin
            left_reg <= ring_q[0].middle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= FW_RESET;
            fh_reg        <= FH_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            flushing_reg  <= 1'b0;
            flush_col_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                if (at_frame_end)
                begin
                    col_reg       <= '0;
                    row_reg       <= '0;
                    flushing_reg  <= 1'b1;
                    flush_col_reg <= '0;
                end
                else if (at_row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (flush_step)
            begin
                if (flush_col_reg == last_col)
                begin
                    flushing_reg <= 1'b0;
                end
                else
                begin
                    flush_col_reg <= flush_col_reg + 1'b1;
                end
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                    default:          ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_position_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_col) && (row_reg <= last_row))
        else $error("Pixel position lies outside the frame.");

    a_flush_covers_row : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(flushing_reg) |-> ($past(flush_col_reg) == $past(last_col)))
        else $error("Row flush ended before the last column.");

    a_frame_end_closes_run : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_end) |-> run_last)
        else $error("Frame end word is not the last word of its run.");
`endif

endmodule

FILE: design/fnd_cell.sv
// ----------------------------------------------------------------------------
// Four-neighbour despeckle line cell
// Holds one column of the two stored lines and passes it to its neighbour
// on every shift; the tail cell takes the new column instead.
// ----------------------------------------------------------------------------
module fnd_cell (
    input  logic                clk,
    input  logic                shift,
    input  logic                take_insert,
    input  fnd_pkg::fnd_column_t from_next,
    input  fnd_pkg::fnd_column_t insert,
    output fnd_pkg::fnd_column_t data
);
    import fnd_pkg::*;

    fnd_column_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= take_insert ? insert : from_next;
        end
    end

    assign data = data_reg;

endmodule

FILE: design/fnd_filter.sv
// ----------------------------------------------------------------------------
// Four-neighbour despeckle filter pipeline
// Compares the centre with its neighbours and sums them in the first stage,
// forms the rounded average in the second and holds the result word in an
// output register with a valid/ready handshake.
// ----------------------------------------------------------------------------
module fnd_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fnd_pkg::fnd_window_t window,
    output logic                can_load,
    output logic                result_valid,
    input  logic                result_ready,
    output fnd_pkg::pix_t       pixel_out,
    output logic                frame_end,
    output logic                run_last
);
    import fnd_pkg::*;

    pix_t             nb_pix [4];
    logic [PIX_W:0]   diff   [4];
    logic [3:0]       near;
    logic [SUM_W-1:0] sum;
    logic [2:0]       cnt;
    logic             pass;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    pix_t             s1_centre_reg;
    logic [SUM_W-1:0] s1_sum_reg;
    logic [2:0]       s1_cnt_reg;
    logic             s1_pass_reg;
    logic             s1_frame_end_reg;
    logic             s1_run_last_reg;

    logic [2*SUM_W-1:0] prod;
    logic [SUM_W-1:0]   quot;
    logic               adv;

    logic out_valid_reg;
    pix_t pixel_out_reg;
    logic frame_end_reg;
    logic run_last_reg;

    assign nb_pix[0] = window.up;
    assign nb_pix[1] = window.left;
    assign nb_pix[2] = window.right;
    assign nb_pix[3] = window.down;

    always_comb
    begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < 4; i++)
        begin
            diff[i] = {1'b0, window.centre} - {1'b0, nb_pix[i]};
            near[i] = window.nb_ok[i]
                      && (diff[i] == '0 || diff[i] == (PIX_W+1)'(1) || diff[i] == '1);
            if (window.nb_ok[i])
            begin
                sum = sum + SUM_W'(nb_pix[i]);
                cnt = cnt + 3'd1;
            end
        end
        pass = (window.nb_ok == 4'b0000) || (near != 4'b0000);
    end

    assign adv      = !out_valid_reg || result_ready;
    assign can_load = !s1_valid_reg || adv;

    always_comb
    begin
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_centre_reg    <= window.centre;
            s1_sum_reg       <= sum + SUM_W'(cnt >> 1);
            s1_cnt_reg       <= cnt;
            s1_pass_reg      <= pass;
            s1_frame_end_reg <= window.frame_end;
            s1_run_last_reg  <= window.run_last;
        end
    end

    // Division by three is a multiplication by the rounded-up reciprocal.
    assign prod = (2*SUM_W)'(s1_sum_reg) * (2*SUM_W)'(DIV3_MULT);

    always_comb
    begin
        case (s1_cnt_reg)
            3'd2:    quot = s1_sum_reg >> 1;
            3'd3:    quot = SUM_W'(prod >> DIV3_SHIFT);
            3'd4:    quot = s1_sum_reg >> 2;
            default: quot = s1_sum_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            pixel_out_reg <= s1_pass_reg ? s1_centre_reg : quot[PIX_W-1:0];
            frame_end_reg <= s1_frame_end_reg;
            run_last_reg  <= s1_run_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign frame_end    = frame_end_reg;
    assign run_last     = run_last_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Four-neighbour despeckle testbench
// Streams frames of pixels into the despeckle filter under random source and
// sink stalls, and checks every filtered word against a cycle-free predictor
// of the filter. Frame size is changed between phases, covering one-pixel,
// one-row, full-width and clamped register values, smooth and noisy content.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fnd_pkg::*;

    localparam int MAX_COLS       = 32;
    localparam int MAX_ROWS       = 1024;
    localparam int SETTLE_CYCLES  = 48;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 260;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        pix_t pixel;
        logic frame_end;
        logic run_last;
    } filtered_word_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_ready;
    pix_t                 pixel_in     = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    pix_t                 pixel_out;
    logic                 frame_end;
    logic                 run_last;

    pix_t           pending_pixels[$];
    filtered_word_t expected_words[$];

    logic [FW_W-1:0] width_setting  = FW_RESET;
    logic [FH_W-1:0] height_setting = FH_RESET;
    pix_t            upper_row[MAX_COLS];
    pix_t            middle_row[MAX_COLS];
    int unsigned     next_col = 0;
    int unsigned     next_row = 0;

    bit          send_steady  = 1'b0;
    bit          recv_steady  = 1'b0;
    bit          squeeze      = 1'b0;
    bit          squeeze_done;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned receive_wait;
    int unsigned quiet_cycles = 0;
    int unsigned words_seen   = 0;
    int unsigned mismatches   = 0;

    four_neighbour_despeckle dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_in     (pixel_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel_out    (pixel_out),
        .frame_end    (frame_end),
        .run_last     (run_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_setting == 0)
            return 1;
        if (width_setting > MAX_COLS)
            return MAX_COLS;
        return width_setting;
    endfunction

    function automatic int unsigned active_height();
        if (height_setting == 0)
            return 1;
        if (height_setting > MAX_ROWS)
            return MAX_ROWS;
        return height_setting;
    endfunction

    function automatic int unsigned draw_wait(bit steady);
        if (steady)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic pix_t despeckle_pixel(pix_t centre, pix_t nb[4], int unsigned count);
        int unsigned total;
        total = 0;
        if (count == 0)
            return centre;
        for (int k = 0; k < count; k++)
        begin
            if ((centre > nb[k] ? centre - nb[k] : nb[k] - centre) <= 1)
                return centre;
            total += nb[k];
        end
        return pix_t'((total + count / 2) / count);
    endfunction

    // The word of the row above is released once the pixel below it arrives;
    // the last pixel of a frame also releases the whole final row.
    function automatic void predict_pixel(pix_t value);
        int unsigned    w;
        int unsigned    h;
        int unsigned    c;
        int unsigned    r;
        int unsigned    count;
        pix_t           nb[4];
        filtered_word_t word;
        filtered_word_t batch[$];
        w = active_width();
        h = active_height();
        if (next_col >= w)
            next_col = 0;
        if (next_row >= h)
            next_row = 0;
        c = next_col;
        r = next_row;
        if (r >= 1)
        begin
            count = 0;
            if (r >= 2)
            begin
                nb[count] = upper_row[c];
                count++;
            end
            if (c > 0)
            begin
                nb[count] = upper_row[c - 1];
                count++;
            end
            if (c + 1 < w)
            begin
                nb[count] = middle_row[c + 1];
                count++;
            end
            nb[count] = value;
            count++;
            word.pixel     = despeckle_pixel(middle_row[c], nb, count);
            word.frame_end = 1'b0;
            word.run_last  = 1'b0;
            batch.push_back(word);
        end
        upper_row[c]  = middle_row[c];
        middle_row[c] = value;
        if (c + 1 == w && r + 1 == h)
        begin
            for (int k = 0; k < w; k++)
            begin
                count = 0;
                if (h > 1)
                begin
                    nb[count] = upper_row[k];
                    count++;
                end
                if (k > 0)
                begin
                    nb[count] = middle_row[k - 1];
                    count++;
                end
                if (k + 1 < w)
                begin
                    nb[count] = middle_row[k + 1];
                    count++;
                end
                word.pixel     = despeckle_pixel(middle_row[k], nb, count);
                word.frame_end = (k + 1 == w);
                word.run_last  = 1'b0;
                batch.push_back(word);
            end
            next_col = 0;
            next_row = 0;
        end
        else
        begin
            next_col = c + 1;
            if (next_col >= w)
            begin
                next_col = 0;
                next_row = (r + 1) % MAX_ROWS;
            end
        end
        if (batch.size() != 0)
            batch[batch.size() - 1].run_last = 1'b1;
        foreach (batch[i])
            expected_words.push_back(batch[i]);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] word %0d: %s", $realtime, words_seen, msg);
    endtask

    task automatic check_word();
        filtered_word_t want;
        words_seen++;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word, pixel_out %0d", pixel_out));
            return;
        end
        want = expected_words.pop_front();
        if (pixel_out !== want.pixel)
            report_mismatch($sformatf("pixel_out %0d, expected %0d", pixel_out, want.pixel));
        if (frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b", frame_end, want.frame_end));
        if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b", run_last, want.run_last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel_in    <= '0;
            send_gap    <= 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
                predict_pixel(pixel_in);
            if (!pixel_valid || pixel_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap    <= send_gap - 1;
                    pixel_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    pixel_valid <= 1'b1;
                    pixel_in    <= pending_pixels.pop_front();
                    send_gap    <= draw_wait(send_steady);
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
            squeeze_done <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_word();
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else if (result_valid && result_ready)
            begin
                if (squeeze && !squeeze_done)
                begin
                    squeeze_done <= 1'b1;
                    receive_wait = LONG_HOLD;
                end
                else
                    receive_wait = draw_wait(recv_steady);
                result_ready <= (receive_wait == 0);
                stall_left   <= (receive_wait > 0) ? receive_wait - 1 : 0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("four_neighbour_despeckle test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] index, int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == REG_FRAME_WIDTH)
            width_setting = FW_W'(value);
        else
            height_setting = FH_W'(value);
        next_col = 0;
        next_row = 0;
    endtask

    task automatic push_pixel(int unsigned value);
        pending_pixels.push_back(pix_t'(value));
    endtask

    // Smooth runs keep neighbours within a few levels of each other, so that
    // isolated impulses and near-threshold differences both turn up.
    task automatic queue_pixels(int unsigned count);
        bit smooth;
        int base;
        int v;
        @(negedge clk);
        smooth = ($urandom_range(0, 2) != 0);
        base   = $urandom_range(0, 255);
        repeat (count)
        begin
            if (!smooth || $urandom_range(0, 6) == 0)
                v = $urandom_range(0, 255);
            else
            begin
                v = base + int'($urandom_range(0, 4)) - 2;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            pending_pixels.push_back(pix_t'(v));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || pixel_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned choice;
        int unsigned count;
        int unsigned random_count;
        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Frame size straight out of reset, left unfinished.
        queue_pixels(45);
        wait_idle();

        // One-pixel frames from zero width and height.
        write_register(REG_FRAME_WIDTH, 0);
        write_register(REG_FRAME_HEIGHT, 0);
        @(negedge clk);
        push_pixel(0);
        push_pixel(255);
        push_pixel(128);
        wait_idle();

        // Three by three frame with an impulse and rounding to the half.
        write_register(REG_FRAME_WIDTH, 3);
        write_register(REG_FRAME_HEIGHT, 3);
        @(negedge clk);
        push_pixel(0);
        push_pixel(10);
        push_pixel(0);
        push_pixel(11);
        push_pixel(200);
        push_pixel(11);
        push_pixel(0);
        push_pixel(10);
        push_pixel(0);
        wait_idle();

        // One-row frame of full-scale alternating values.
        write_register(REG_FRAME_HEIGHT, 1);
        @(negedge clk);
        push_pixel(255);
        push_pixel(0);
        push_pixel(255);
        wait_idle();

        // Single column with the height register at its top, left unfinished.
        write_register(REG_FRAME_WIDTH, 0);
        write_register(REG_FRAME_HEIGHT, 2047);
        queue_pixels(8);
        wait_idle();

        // Full-width frame while the sink holds off for a long stretch.
        write_register(REG_FRAME_WIDTH, 63);
        write_register(REG_FRAME_HEIGHT, 4);
        send_steady = 1'b1;
        squeeze     = 1'b1;
        queue_pixels(128);
        wait_idle();
        squeeze      = 1'b0;
        send_steady  = 1'b0;
        random_count = 196;

        while (random_count < RANDOM_ITEMS)
        begin
            choice      = $urandom_range(0, 9);
            send_steady = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            if (choice <= 4)
            begin
                write_register(REG_FRAME_WIDTH, $urandom_range(0, 6));
                write_register(REG_FRAME_HEIGHT, $urandom_range(0, 5));
                count = active_width() * active_height() * $urandom_range(1, 2);
            end
            else if (choice == 5)
            begin
                write_register(REG_FRAME_WIDTH, $urandom_range(32, 63));
                write_register(REG_FRAME_HEIGHT, $urandom_range(1, 2));
                count = active_width() * active_height();
            end
            else if (choice == 6)
            begin
                write_register(REG_FRAME_WIDTH, $urandom_range(0, 2));
                write_register(REG_FRAME_HEIGHT, $urandom_range(MAX_ROWS, 2047));
                count = $urandom_range(5, 30);
            end
            else if (choice == 7)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_register(REG_FRAME_WIDTH, $urandom_range(1, 8));
                else
                    write_register(REG_FRAME_HEIGHT, $urandom_range(1, 6));
                count = active_width() * active_height();
                if (count > 64)
                    count = $urandom_range(10, 64);
            end
            else if (choice == 8)
            begin
                write_register(REG_FRAME_WIDTH, $urandom_range(2, 6));
                write_register(REG_FRAME_HEIGHT, $urandom_range(2, 5));
                count = $urandom_range(1, active_width() * active_height() - 1);
            end
            else
                count = $urandom_range(1, 20);
            queue_pixels(count);
            random_count += count;
            wait_idle();
        end

        if (mismatches == 0 && expected_words.size() == 0)
            $display("four_neighbour_despeckle test passed");
        else
            $display("four_neighbour_despeckle test failed");
        $finish;
    end

endmodule
